### hw/rtl/dag_longest_path_unit_defines.svh
// Assertion macros for the DAG longest path unit.
// Used by the top level; relies on clk_i and rst_ni in the including scope.
`ifndef DAG_LONGEST_PATH_UNIT_DEFINES_SVH
`define DAG_LONGEST_PATH_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define DLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define DLP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/dlp_pkg.sv
// Shared constants and controller/datapath interface types for the DAG longest path unit.
// No dependencies.
package dlp_pkg;

  localparam int NODES           = 256;
  localparam int NODE_W          = 8;
  localparam int CNT_W           = 9;
  localparam int TIME_W          = 24;
  localparam int LEN_W           = 25;
  localparam int WEIGHT_W        = 16;
  localparam int MAX_EDGES_DEF   = 1024;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Commands from the controller to the datapath
  typedef struct packed {
    logic idle;
    logic load_edge;
    logic store_edge;
    logic start_walk;
    logic scan;
    logic pop;
    logic fetch_node;
    logic load_head;
    logic take_edge;
    logic update;
    logic start_max;
    logic max_scan;
    logic emit;
  } dlp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic edge_ok;
    logic scan_done;
    logic queue_empty;
    logic link_zero;
    logic out_busy;
  } dlp_sts_t;

endpackage

### hw/rtl/dag_longest_path_unit.sv
// Top level of the DAG longest path unit: controller plus datapath.
// Depends on dlp_pkg, dlp_ctrl, dlp_dpath and dag_longest_path_unit_defines.svh.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  kind, from_node, to_node, weight
//   out      output     out_valid_o/out_stall_i project_length, edge_dropped
//   cfg      input      cfg_valid_i/cfg_ready_o node_count
//
// An edge item reads the list head and in-degree, then does the writes; a dropped edge
// only sets the drop flag. A finish item scans the nodes, walks the queued nodes and
// their edges, then scans the nodes again for the largest time.
// Reset clears valid bits at once, so there is no clearing pass after reset.
// A finished result waits in the output register; a later finish holds until it leaves.
`include "dag_longest_path_unit_defines.svh"
module dag_longest_path_unit import dlp_pkg::*; #(
  parameter int MAX_EDGES   = MAX_EDGES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  logic [NODE_W-1:0]   from_node_i,
  input  logic [NODE_W-1:0]   to_node_i,
  input  logic [WEIGHT_W-1:0] weight_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [LEN_W-1:0]    project_length_o,
  output logic                edge_dropped_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CNT_W-1:0]    node_count_i
);

  dlp_cmd_t cmd;
  dlp_sts_t sts;

  dlp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .kind_i, .sts_i(sts), .cmd_o(cmd)
  );

  dlp_dpath #(.MAX_EDGES(MAX_EDGES), .WEIGHT_BITS(WEIGHT_BITS)) u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .cfg_valid_i, .node_count_i,
    .from_node_i, .to_node_i, .weight_i, .out_stall_i, .out_valid_o,
    .project_length_o, .edge_dropped_o
  );

  // Take items and configuration only while idle
  assign in_stall_o  = !cmd.idle;
  assign cfg_ready_o = cmd.idle;

  // A finish item busies the block on the next cycle
  `DLP_ASSERT_NXT(a_finish_busy, in_valid_i && !in_stall_o && kind_i, in_stall_o, "finish idle")
  // A new result appears only as the block returns to idle
  `DLP_ASSERT_IMP(a_result_idle, $rose(out_valid_o), !in_stall_o, "result raised while busy")
  // An edge item never produces a result
  `DLP_ASSERT_NXT(a_edge_quiet, in_valid_i && !in_stall_o && !kind_i, !$rose(out_valid_o), "edge result")

endmodule

### hw/rtl/dlp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

### hw/rtl/dlp_ctrl.sv
// Controller state machine for the DAG longest path unit: sequences edge loading,
// the topological walk and the final maximum scan. Depends on dlp_pkg.
module dlp_ctrl import dlp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     kind_i,
  input  dlp_sts_t sts_i,
  output dlp_cmd_t cmd_o
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_EWR  = 4'd1;
  localparam logic [3:0] ST_SCAN = 4'd2;
  localparam logic [3:0] ST_POP  = 4'd3;
  localparam logic [3:0] ST_NODE = 4'd4;
  localparam logic [3:0] ST_HEAD = 4'd5;
  localparam logic [3:0] ST_TEST = 4'd6;
  localparam logic [3:0] ST_EDGE = 4'd7;
  localparam logic [3:0] ST_UPD  = 4'd8;
  localparam logic [3:0] ST_MAX  = 4'd9;
  localparam logic [3:0] ST_OUT  = 4'd10;

  logic [3:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.idle = 1'b1;
        if (in_valid_i) begin
          if (kind_i) begin
            cmd_o.start_walk = 1'b1;
            state_d = ST_SCAN;
          end else begin
            cmd_o.load_edge = 1'b1;
            if (sts_i.edge_ok) state_d = ST_EWR;
          end
        end
      end
      ST_EWR: begin
        cmd_o.store_edge = 1'b1;
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) state_d = ST_POP;
      end
      ST_POP: begin
        if (sts_i.queue_empty) begin
          cmd_o.start_max = 1'b1;
          state_d = ST_MAX;
        end else begin
          cmd_o.pop = 1'b1;
          state_d = ST_NODE;
        end
      end
      ST_NODE: begin
        cmd_o.fetch_node = 1'b1;
        state_d = ST_HEAD;
      end
      ST_HEAD: begin
        cmd_o.load_head = 1'b1;
        state_d = ST_TEST;
      end
      ST_TEST: begin
        if (sts_i.link_zero) begin
          state_d = ST_POP;
        end else begin
          state_d = ST_EDGE;
        end
      end
      ST_EDGE: begin
        cmd_o.take_edge = 1'b1;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d = ST_TEST;
      end
      ST_MAX: begin
        cmd_o.max_scan = 1'b1;
        if (sts_i.scan_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/dlp_dpath.sv
// Datapath of the DAG longest path unit: edge, list head, in-degree, time and queue
// memories, valid bits on the head, in-degree and time memories, walk counters and
// the result register. Depends on dlp_pkg and dlp_ram.
module dlp_dpath import dlp_pkg::*; #(
  parameter int MAX_EDGES   = MAX_EDGES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dlp_cmd_t            cmd_i,
  output dlp_sts_t            sts_o,
  input  logic                cfg_valid_i,
  input  logic [CNT_W-1:0]    node_count_i,
  input  logic [NODE_W-1:0]   from_node_i,
  input  logic [NODE_W-1:0]   to_node_i,
  input  logic [WEIGHT_W-1:0] weight_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [LEN_W-1:0]    project_length_o,
  output logic                edge_dropped_o
);

  localparam int LINK_W  = $clog2(MAX_EDGES + 1);
  localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int WB      = WEIGHT_BITS;
  localparam int ED_W    = NODE_W + WB + LINK_W;
  localparam int SUM_W   = ((WB > TIME_W) ? WB : TIME_W) + 1;

  // Configuration and load state
  logic [CNT_W-1:0]    node_cnt_q;
  logic [LINK_W-1:0]   total_q;
  logic                drop_q;
  logic [NODE_W-1:0]   from_q, to_q;
  logic [WB-1:0]       w_q;

  // Walk state
  logic [CNT_W-1:0]    idx_q, qh_q, qt_q;
  logic                pend_q;
  logic [NODE_W-1:0]   pidx_q, v_q;
  logic [LINK_W-1:0]   link_q;
  logic [TIME_W-1:0]   tu_q, tnew_q, best_q;

  // Result register
  logic                out_valid_q;
  logic [LEN_W-1:0]    len_q;
  logic                drop_out_q;

  // Valid bits for memories that reset to zero
  logic [NODES-1:0]    hd_vld_q, dg_vld_q, tm_vld_q;
  logic                hd_rv_q, dg_rv_q, tm_rv_q;

  // Memory ports
  logic                ed_we, hd_we, dg_we, tm_we, qu_we;
  logic [EDGE_AW-1:0]  ed_waddr, ed_raddr;
  logic [ED_W-1:0]     ed_wdata, ed_rdata;
  logic [NODE_W-1:0]   hd_waddr, hd_raddr, dg_waddr, dg_raddr, tm_waddr, tm_raddr;
  logic [NODE_W-1:0]   qu_waddr, qu_raddr, qu_wdata, qu_rdata;
  logic [LINK_W-1:0]   hd_wdata, hd_rdata, dg_wdata, dg_rdata;
  logic [TIME_W-1:0]   tm_wdata, tm_rdata;

  logic [LINK_W-1:0]   head_eff, deg_eff, link_m1;
  logic [TIME_W-1:0]   time_eff, tsat;
  logic [NODE_W-1:0]   ed_to;
  logic [WB-1:0]       ed_w;
  logic [LINK_W-1:0]   ed_next;
  logic [SUM_W-1:0]    sum;
  logic                issue, push_scan, push_upd, cfg_we;
  logic [CNT_W-1:0]    cfg_clamp;

  assign head_eff = hd_rv_q ? hd_rdata : '0;
  assign deg_eff  = dg_rv_q ? dg_rdata : '0;
  assign time_eff = tm_rv_q ? tm_rdata : '0;
  assign link_m1  = link_q - LINK_W'(1);
  assign {ed_to, ed_w, ed_next} = ed_rdata;

  // Saturating time sum along an edge
  assign sum  = SUM_W'(tu_q) + SUM_W'(ed_w);
  assign tsat = (sum > SUM_W'(TIME_MAX)) ? TIME_MAX : sum[TIME_W-1:0];

  assign issue     = idx_q < node_cnt_q;
  assign push_scan = cmd_i.scan && pend_q && (deg_eff == '0);
  assign push_upd  = cmd_i.update && (deg_eff == LINK_W'(1));

  // Status toward the controller
  assign sts_o.edge_ok     = ({1'b0, from_node_i} < node_cnt_q) &&
                             ({1'b0, to_node_i} < node_cnt_q) &&
                             (total_q != LINK_W'(MAX_EDGES));
  assign sts_o.scan_done   = !issue && !pend_q;
  assign sts_o.queue_empty = qh_q == qt_q;
  assign sts_o.link_zero   = link_q == '0;
  assign sts_o.out_busy    = out_valid_q && out_stall_i;

  // Clamp the node count: zero reads as one, above the store as full
  assign cfg_we = cfg_valid_i && cmd_i.idle;
  always_comb begin
    cfg_clamp = node_count_i;
    if (node_count_i == '0) cfg_clamp = CNT_W'(1);
    else if (node_count_i > CNT_W'(NODES)) cfg_clamp = CNT_W'(NODES);
  end

  // Memory address and write selection
  always_comb begin
    ed_we    = cmd_i.store_edge;
    ed_waddr = total_q[EDGE_AW-1:0];
    ed_wdata = {to_q, w_q, head_eff};
    ed_raddr = link_m1[EDGE_AW-1:0];

    hd_we    = cmd_i.store_edge;
    hd_waddr = from_q;
    hd_wdata = total_q + LINK_W'(1);
    hd_raddr = cmd_i.fetch_node ? qu_rdata : from_node_i;

    dg_we    = cmd_i.store_edge || (cmd_i.update && deg_eff != '0);
    dg_waddr = cmd_i.update ? v_q : to_q;
    dg_wdata = cmd_i.update ? deg_eff - LINK_W'(1) : deg_eff + LINK_W'(1);
    dg_raddr = to_node_i;
    if (cmd_i.scan) dg_raddr = idx_q[NODE_W-1:0];
    else if (cmd_i.take_edge) dg_raddr = ed_to;

    tm_we    = cmd_i.update && (tnew_q > time_eff);
    tm_waddr = v_q;
    tm_wdata = tnew_q;
    tm_raddr = qu_rdata;
    if (cmd_i.take_edge) tm_raddr = ed_to;
    else if (cmd_i.max_scan) tm_raddr = idx_q[NODE_W-1:0];

    qu_we    = push_scan || push_upd;
    qu_waddr = qt_q[NODE_W-1:0];
    qu_wdata = cmd_i.update ? v_q : pidx_q;
    qu_raddr = qh_q[NODE_W-1:0];
  end

  dlp_ram #(.WIDTH(ED_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk_i, .we_i(ed_we), .waddr_i(ed_waddr), .wdata_i(ed_wdata),
    .raddr_i(ed_raddr), .rdata_o(ed_rdata)
  );
  dlp_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) u_head_ram (
    .clk_i, .we_i(hd_we), .waddr_i(hd_waddr), .wdata_i(hd_wdata),
    .raddr_i(hd_raddr), .rdata_o(hd_rdata)
  );
  dlp_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) u_deg_ram (
    .clk_i, .we_i(dg_we), .waddr_i(dg_waddr), .wdata_i(dg_wdata),
    .raddr_i(dg_raddr), .rdata_o(dg_rdata)
  );
  dlp_ram #(.WIDTH(TIME_W), .DEPTH(NODES)) u_time_ram (
    .clk_i, .we_i(tm_we), .waddr_i(tm_waddr), .wdata_i(tm_wdata),
    .raddr_i(tm_raddr), .rdata_o(tm_rdata)
  );
  dlp_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_queue_ram (
    .clk_i, .we_i(qu_we), .waddr_i(qu_waddr), .wdata_i(qu_wdata),
    .raddr_i(qu_raddr), .rdata_o(qu_rdata)
  );

  // Valid bits: set on write, drop all when a result is emitted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hd_vld_q <= '0;
      dg_vld_q <= '0;
      tm_vld_q <= '0;
      hd_rv_q  <= 1'b0;
      dg_rv_q  <= 1'b0;
      tm_rv_q  <= 1'b0;
    end else begin
      hd_rv_q <= hd_vld_q[hd_raddr];
      dg_rv_q <= dg_vld_q[dg_raddr];
      tm_rv_q <= tm_vld_q[tm_raddr];
      if (cmd_i.emit) begin
        hd_vld_q <= '0;
        dg_vld_q <= '0;
        tm_vld_q <= '0;
      end else begin
        if (hd_we) hd_vld_q[hd_waddr] <= 1'b1;
        if (dg_we) dg_vld_q[dg_waddr] <= 1'b1;
        if (tm_we) tm_vld_q[tm_waddr] <= 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_cnt_q  <= CNT_W'(NODES);
      total_q     <= '0;
      drop_q      <= 1'b0;
      idx_q       <= '0;
      qh_q        <= '0;
      qt_q        <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we) node_cnt_q <= cfg_clamp;
      if (cmd_i.load_edge && !sts_o.edge_ok) drop_q <= 1'b1;
      if (cmd_i.store_edge) total_q <= total_q + LINK_W'(1);
      // start both scans from node zero
      if (cmd_i.start_walk || cmd_i.start_max) begin
        idx_q  <= '0;
        pend_q <= 1'b0;
      end else if (cmd_i.scan || cmd_i.max_scan) begin
        pend_q <= issue;
        if (issue) idx_q <= idx_q + CNT_W'(1);
      end
      if (cmd_i.start_walk) begin
        qh_q <= '0;
        qt_q <= '0;
      end else begin
        if (cmd_i.pop) qh_q <= qh_q + CNT_W'(1);
        if (qu_we) qt_q <= qt_q + CNT_W'(1);
      end
      // result register: hold while stalled
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        total_q     <= '0;
        drop_q      <= 1'b0;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_edge) begin
      from_q <= from_node_i;
      to_q   <= to_node_i;
      w_q    <= WB'(weight_i);
    end
    if (cmd_i.scan || cmd_i.max_scan) pidx_q <= idx_q[NODE_W-1:0];
    if (cmd_i.load_head) begin
      link_q <= head_eff;
      tu_q   <= time_eff;
    end
    if (cmd_i.take_edge) begin
      v_q    <= ed_to;
      link_q <= ed_next;
      tnew_q <= tsat;
    end
    if (cmd_i.start_max) best_q <= '0;
    else if (cmd_i.max_scan && pend_q && time_eff > best_q) best_q <= time_eff;
    if (cmd_i.emit) begin
      len_q      <= LEN_W'(best_q) + LEN_W'(1);
      drop_out_q <= drop_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign project_length_o = len_q;
  assign edge_dropped_o   = drop_out_q;

endmodule

### bench/dag_longest_path_unit_test.sv
// Testbench for the DAG longest path unit: directed and random graphs, checked against
// a behavioral longest-path predictor. Depends on dlp_pkg and dag_longest_path_unit.
`timescale 1ns / 1ps

module dag_longest_path_unit_test;
  import dlp_pkg::*;

  localparam int EDGE_CAP = MAX_EDGES_DEF;

  typedef struct packed {
    logic [LEN_W-1:0] project_length;
    logic             edge_dropped;
  } path_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                kind_i = 1'b0;
  logic [NODE_W-1:0]   from_node_i = '0;
  logic [NODE_W-1:0]   to_node_i = '0;
  logic [WEIGHT_W-1:0] weight_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [LEN_W-1:0]    project_length_o;
  logic                edge_dropped_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CNT_W-1:0]    node_count_i = '0;

  dag_longest_path_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .from_node_i, .to_node_i,
    .weight_i, .out_valid_o, .out_stall_i, .project_length_o, .edge_dropped_o,
    .cfg_valid_i, .cfg_ready_o, .node_count_i
  );

  always #2 clk_i = ~clk_i;

  // Predictor state: stored graph and configuration
  int unsigned  node_limit;
  int unsigned  edge_src[$];
  int unsigned  edge_dst[$];
  int unsigned  edge_wt[$];
  bit           drop_seen;
  path_result_t expected_lengths[$];
  int           error_count = 0;
  bit           idle_enable = 1'b1;

  // Add one edge to the predicted graph
  function automatic void record_edge(int unsigned src, int unsigned dst, int unsigned w);
    if (src >= node_limit || dst >= node_limit || edge_src.size() >= EDGE_CAP) begin
      drop_seen = 1'b1;
    end else begin
      edge_src.push_back(src);
      edge_dst.push_back(dst);
      edge_wt.push_back(w);
    end
  endfunction

  // Walk the graph in topological order; newest edge of a node comes first
  function automatic path_result_t compute_length();
    int unsigned  indeg[NODES];
    int unsigned  etime[NODES];
    int unsigned  order[$];
    int unsigned  best;
    int unsigned  u;
    longint unsigned t;
    path_result_t r;
    best = 0;
    foreach (indeg[i]) begin
      indeg[i] = 0;
      etime[i] = 0;
    end
    foreach (edge_dst[e]) indeg[edge_dst[e]]++;
    for (int i = 0; i < node_limit; i++) if (indeg[i] == 0) order.push_back(i);
    while (order.size() > 0) begin
      u = order.pop_front();
      for (int e = edge_src.size() - 1; e >= 0; e--) begin
        if (edge_src[e] == u) begin
          t = longint'(etime[u]) + edge_wt[e];
          if (t > TIME_MAX) t = TIME_MAX;
          if (t > etime[edge_dst[e]]) etime[edge_dst[e]] = 32'(t);
          if (indeg[edge_dst[e]] > 0) begin
            indeg[edge_dst[e]]--;
            if (indeg[edge_dst[e]] == 0) order.push_back(edge_dst[e]);
          end
        end
      end
    end
    for (int i = 0; i < node_limit; i++) if (etime[i] > best) best = etime[i];
    r.project_length = LEN_W'(best) + LEN_W'(1);
    r.edge_dropped = drop_seen;
    edge_src.delete();
    edge_dst.delete();
    edge_wt.delete();
    drop_seen = 1'b0;
    return r;
  endfunction

  // Send one item, with an optional idle burst before it
  task automatic send_item(bit kind, int unsigned src, int unsigned dst, int unsigned w);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    from_node_i <= NODE_W'(src);
    to_node_i   <= NODE_W'(dst);
    weight_i    <= WEIGHT_W'(w);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (kind) expected_lengths.push_back(compute_length());
    else record_edge(NODE_W'(src), NODE_W'(dst), WEIGHT_W'(w));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_lengths.size() > 0) @(posedge clk_i);
    // finish of a later walk may still be running; leave room
    repeat (20) @(posedge clk_i);
  endtask

  // Write node_count while idle
  task automatic set_node_count(int unsigned value);
    int unsigned eff;
    drain_results();
    cfg_valid_i  <= 1'b1;
    node_count_i <= CNT_W'(value);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    eff = value == 0 ? 1 : (value > NODES ? NODES : value);
    node_limit = eff;
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_lengths.size() == 0) begin
        $display("%0t: unexpected result length=%0d dropped=%0d", $time,
                 project_length_o, edge_dropped_o);
        error_count++;
      end else begin
        path_result_t exp_r;
        exp_r = expected_lengths.pop_front();
        if (exp_r.project_length !== project_length_o) begin
          $display("%0t: project_length expected %0d actual %0d", $time,
                   exp_r.project_length, project_length_o);
          error_count++;
        end
        if (exp_r.edge_dropped !== edge_dropped_o) begin
          $display("%0t: edge_dropped expected %0d actual %0d", $time,
                   exp_r.edge_dropped, edge_dropped_o);
          error_count++;
        end
      end
    end
  end

  // Random stall bursts on the result side
  initial begin
    forever begin
      @(posedge clk_i);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  task automatic test_directed();
    // single node, empty graph
    set_node_count(0);
    send_item(1'b1, 0, 0, 0);
    // chain with extreme weights
    set_node_count(NODES);
    for (int i = 0; i < 8; i++) send_item(1'b0, i, i + 1, 16'hFFFF);
    send_item(1'b0, 0, 255, 0);
    send_item(1'b0, 255, 254, 16'h5A5A);
    send_item(1'b1, 0, 0, 0);
    // out of range end points
    set_node_count(4);
    send_item(1'b0, 0, 3, 7);
    send_item(1'b0, 4, 1, 3);
    send_item(1'b0, 1, 255, 3);
    send_item(1'b1, 255, 255, 16'hFFFF);
    // cycle: nodes on it never walked
    send_item(1'b0, 0, 1, 5);
    send_item(1'b0, 1, 2, 5);
    send_item(1'b0, 2, 1, 5);
    send_item(1'b0, 2, 3, 9);
    send_item(1'b1, 0, 0, 0);
    // pressure: wait until all results have come
    drain_results();
  endtask

  task automatic test_shrunk_count();
    set_node_count(NODES);
    send_item(1'b0, 10, 200, 100);
    send_item(1'b0, 200, 3, 50);
    send_item(1'b0, 0, 10, 1);
    set_node_count(8);
    send_item(1'b1, 0, 0, 0);
  endtask

  task automatic test_store_full();
    set_node_count(NODES);
    for (int i = 0; i < EDGE_CAP + 2; i++)
      send_item(1'b0, $urandom_range(0, 127), $urandom_range(128, 255), $urandom);
    send_item(1'b1, 0, 0, 0);
  endtask

  task automatic test_random();
    int unsigned n, len;
    for (int g = 0; g < 60; g++) begin
      if (g % 15 == 0) set_node_count($urandom_range(0, 3) == 0 ? 511 : $urandom_range(2, 40));
      if (g == 45) idle_enable = 1'b0;
      n = node_limit;
      len = $urandom_range(0, 12);
      for (int k = 0; k < len; k++) begin
        int unsigned a, b;
        a = $urandom_range(0, n - 1);
        b = $urandom_range(0, n - 1);
        if ($urandom_range(0, 9) == 0) send_item(1'b0, $urandom, $urandom, $urandom);
        else if ($urandom_range(0, 5) != 0 && a != b)
          send_item(1'b0, a < b ? a : b, a < b ? b : a,
                    $urandom_range(0, 1) ? $urandom : $urandom_range(0, 20));
        else send_item(1'b0, a, b, $urandom);
      end
      send_item(1'b1, $urandom, $urandom, $urandom);
    end
    for (int g = 0; g < 40; g++) begin
      set_node_count($urandom_range(1, 256));
      send_item(1'b1, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    node_limit = NODES;
    drop_seen = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_shrunk_count();
    test_store_full();
    test_random();
    drain_results();
    if (error_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/dlp_pkg.sv
hw/rtl/dlp_ram.sv
hw/rtl/dlp_ctrl.sv
hw/rtl/dlp_dpath.sv
hw/rtl/dag_longest_path_unit.sv
bench/dag_longest_path_unit_test.sv
